>>> design/swsfr_pkg.sv
// Shared types and constants for the single-wire sensor frame receiver.
// No dependencies.
package swsfr_pkg;

    localparam int TICK_W  = 8;
    localparam int WORD_W  = 16;
    localparam int FRAME_W = 40;
    localparam int COUNT_W = 6;

    localparam logic [COUNT_W-1:0] FRAME_BITS = 6'd40;
    localparam logic [TICK_W-1:0]  THRESHOLD_RESET = 8'd4;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_PULSE = 1'b1;

    typedef struct packed {
        logic [WORD_W-1:0] humidity_word;
        logic [WORD_W-1:0] temperature_word;
        logic              checksum_ok;
    } frame_result_t;

endpackage

>>> design/swsfr_if.sv
// Valid/ready channel interfaces for the input items and the frame results.
// Depends on swsfr_pkg.
interface swsfr_in_if
    import swsfr_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              action;
    logic [TICK_W-1:0] pulse_ticks;

    modport source (output valid, output action, output pulse_ticks, input ready);
    modport sink   (input valid, input action, input pulse_ticks, output ready);
endinterface

interface swsfr_out_if
    import swsfr_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] humidity_word;
    logic [WORD_W-1:0] temperature_word;
    logic              checksum_ok;

    modport source (output valid, output humidity_word, output temperature_word,
                    output checksum_ok, input ready);
    modport sink   (input valid, input humidity_word, input temperature_word,
                    input checksum_ok, output ready);
endinterface

>>> design/swsfr_assembler.sv
// Frame state, bit decode and result formation for one input transfer.
// Depends on swsfr_pkg.
module swsfr_assembler
    import swsfr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [TICK_W-1:0]   cfg_wdata,
    input  logic                accept,
    input  logic                action,
    input  logic [TICK_W-1:0]   pulse_ticks,
    output logic                result_valid,
    output frame_result_t       result
);

    logic [TICK_W-1:0]  threshold_reg;
    logic               active_reg, active_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [FRAME_W-1:0] shift_reg, shift_next;

    logic               bit_val;
    logic [FRAME_W-1:0] shifted;
    logic               last_bit;
    logic [7:0]         b0, b1, b2, b3, b4;
    logic [7:0]         byte_sum;

    assign bit_val  = (pulse_ticks > threshold_reg);
    assign shifted  = {shift_reg[FRAME_W-2:0], bit_val};
    assign last_bit = (count_reg == FRAME_BITS - 6'd1);

    assign b0 = shifted[39:32];
    assign b1 = shifted[31:24];
    assign b2 = shifted[23:16];
    assign b3 = shifted[15:8];
    assign b4 = shifted[7:0];
    assign byte_sum = b0 + b1 + b2 + b3;

    always_comb
    begin
        active_next  = active_reg;
        count_next   = count_reg;
        shift_next   = shift_reg;
        result_valid = 1'b0;
        if (accept)
        begin
            case (action)
                ACT_START:
                begin
                    active_next = 1'b1;
                    count_next  = '0;
                    shift_next  = '0;
                end
                ACT_PULSE:
                begin
                    // pulses outside a frame are dropped
                    if (active_reg)
                    begin
                        shift_next = shifted;
                        if (last_bit)
                        begin
                            active_next  = 1'b0;
                            count_next   = '0;
                            result_valid = 1'b1;
                        end
                        else
                        begin
                            count_next = count_reg + 6'd1;
                        end
                    end
                end
                default:
                begin
                    active_next = active_reg;
                end
            endcase
        end
    end

    assign result.humidity_word    = {b0, b1};
    assign result.temperature_word = {b2, b3};
    assign result.checksum_ok      = (byte_sum == b4);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
            active_reg    <= 1'b0;
            count_reg     <= '0;
            shift_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                threshold_reg <= cfg_wdata;
            end
            active_reg <= active_next;
            count_reg  <= count_next;
            shift_reg  <= shift_next;
        end
    end

endmodule

>>> design/swsfr_out_buf.sv
// Two-entry output register with skid stage for frame results.
// Depends on swsfr_pkg.
module swsfr_out_buf
    import swsfr_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  frame_result_t push_data,
    output logic          space,
    output logic          out_valid,
    input  logic          out_ready,
    output frame_result_t out_data
);

    logic          main_valid_reg, main_valid_next;
    logic          skid_valid_reg, skid_valid_next;
    frame_result_t main_reg, main_next;
    frame_result_t skid_reg, skid_next;
    logic          take;

    assign take      = main_valid_reg && out_ready;
    assign space     = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            // no push can arrive while the skid holds data
            if (take)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg || take)
            begin
                main_next       = push_data;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (take)
        begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

>>> design/single_wire_sensor_frame_receiver.sv
// Single-wire sensor frame receiver: one input transfer per cycle.
// A frame result is pushed into the output buffer when the 40th data pulse transfer is accepted.
// Throughput: 1 item per cycle while input ready is high; the frame state register and decode set the pace.
// Input ready drops only while both output register and skid stage hold results.
// Reset (rst_n, async, active low) clears the frame state and sets the threshold to 4.
// Depends on swsfr_pkg, swsfr_if, swsfr_assembler, swsfr_out_buf.
module single_wire_sensor_frame_receiver
    import swsfr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [TICK_W-1:0] cfg_wdata,
    swsfr_in_if.sink          in_ch,
    swsfr_out_if.source       out_ch
);

    logic          accept;
    logic          space;
    logic          result_valid;
    frame_result_t result;
    frame_result_t out_data;

    assign in_ch.ready = space;
    assign accept      = in_ch.valid && space;

    swsfr_assembler u_assembler (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .accept       (accept),
        .action       (in_ch.action),
        .pulse_ticks  (in_ch.pulse_ticks),
        .result_valid (result_valid),
        .result       (result)
    );

    swsfr_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (result_valid),
        .push_data (result),
        .space     (space),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_data  (out_data)
    );

    assign out_ch.humidity_word    = out_data.humidity_word;
    assign out_ch.temperature_word = out_data.temperature_word;
    assign out_ch.checksum_ok      = out_data.checksum_ok;

endmodule

>>> tb/tb_single_wire_sensor_frame_receiver.sv
// Self-checking bench for single_wire_sensor_frame_receiver: drives start and pulse
// transfers with random gaps and output stalls, predicts each frame result and checks it.
// Depends on swsfr_pkg, swsfr_if and the design sources.
module tb_single_wire_sensor_frame_receiver;
    import swsfr_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int ITEMS_PER_PHASE = 180;
    localparam int SETTLE_CYCLES = 4;

    // Tracks the frame state of the block and holds the results it must produce.
    class frame_scoreboard;
        logic [TICK_W-1:0]  threshold = THRESHOLD_RESET;
        bit                 active = 1'b0;
        logic [COUNT_W-1:0] nbits = '0;
        logic [FRAME_W-1:0] shift = '0;
        frame_result_t      expected_q[$];
        int                 errors = 0;

        // Returns 1 when the transfer changed the frame state (not an ignored pulse).
        function bit note_item(logic act, logic [TICK_W-1:0] ticks);
            frame_result_t res;
            logic [7:0]    sum;
            if (act == ACT_START)
            begin
                active = 1'b1;
                nbits = '0;
                shift = '0;
                return 1'b1;
            end
            if (!active)
                return 1'b0;
            shift = {shift[FRAME_W-2:0], (ticks > threshold)};
            nbits = nbits + 1'b1;
            if (nbits < FRAME_BITS)
                return 1'b1;
            sum = shift[39:32] + shift[31:24] + shift[23:16] + shift[15:8];
            res.humidity_word = shift[39:24];
            res.temperature_word = shift[23:8];
            res.checksum_ok = (sum == shift[7:0]);
            expected_q.push_back(res);
            active = 1'b0;
            nbits = '0;
            return 1'b1;
        endfunction

        function void check_result(frame_result_t got);
            frame_result_t exp_res;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result: humidity_word %h temperature_word %h checksum_ok %b",
                       got.humidity_word, got.temperature_word, got.checksum_ok);
                errors++;
                return;
            end
            exp_res = expected_q.pop_front();
            if (got.humidity_word !== exp_res.humidity_word)
            begin
                $error("humidity_word: expected %h, actual %h",
                       exp_res.humidity_word, got.humidity_word);
                errors++;
            end
            if (got.temperature_word !== exp_res.temperature_word)
            begin
                $error("temperature_word: expected %h, actual %h",
                       exp_res.temperature_word, got.temperature_word);
                errors++;
            end
            if (got.checksum_ok !== exp_res.checksum_ok)
            begin
                $error("checksum_ok: expected %b, actual %b",
                       exp_res.checksum_ok, got.checksum_ok);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_we;
    logic [TICK_W-1:0] cfg_wdata;

    swsfr_in_if  in_ch();
    swsfr_out_if out_ch();

    single_wire_sensor_frame_receiver u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    frame_scoreboard sb = new();
    bit              steady = 1'b0;
    int              taken_count = 0;
    int              cycles = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one; none while steady is set.
    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    initial
    begin
        int stall;
        stall = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall > 0)
            begin
                stall--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        frame_result_t got;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.humidity_word = out_ch.humidity_word;
            got.temperature_word = out_ch.temperature_word;
            got.checksum_ok = out_ch.checksum_ok;
            sb.check_result(got);
        end
    end

    task automatic send_item(input logic act, input logic [TICK_W-1:0] ticks);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.action      <= act;
        in_ch.pulse_ticks <= ticks;
        do @(posedge clk); while (!in_ch.ready);
        if (sb.note_item(act, ticks))
            taken_count++;
    endtask

    task automatic wait_results();
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [TICK_W-1:0] value);
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.threshold = value;
    endtask

    // Width for a wanted bit, leaning on the values right at the threshold.
    function automatic logic [TICK_W-1:0] pick_ticks(input bit one);
        int r;
        int thr;
        thr = int'(sb.threshold);
        r = $urandom_range(0, 99);
        if (one)
        begin
            if (thr == 255)
                return 8'd255;
            if (r < 25)
                return 8'(thr + 1);
            if (r < 35)
                return 8'd255;
            return 8'($urandom_range(thr + 1, 255));
        end
        if (r < 25)
            return 8'(thr);
        if (r < 35)
            return 8'd0;
        return 8'($urandom_range(0, thr));
    endfunction

    // Start transfer, then the first npulses bits of the frame, MSB first.
    task automatic send_frame(input logic [FRAME_W-1:0] bits, input int npulses);
        send_item(ACT_START, 8'($urandom_range(0, 255)));
        for (int i = 0; i < npulses; i++)
            send_item(ACT_PULSE, pick_ticks(bits[FRAME_W-1-i]));
    endtask

    function automatic logic [FRAME_W-1:0] make_frame(input bit good_sum);
        logic [7:0] b0, b1, b2, b3, sum;
        b0 = 8'($urandom_range(0, 255));
        b1 = 8'($urandom_range(0, 255));
        b2 = 8'($urandom_range(0, 255));
        b3 = 8'($urandom_range(0, 255));
        sum = b0 + b1 + b2 + b3;
        if (!good_sum)
            sum = sum ^ 8'($urandom_range(1, 255));
        return {b0, b1, b2, b3, sum};
    endfunction

    task automatic random_phase(input int quota);
        int r;
        int stop_at;
        stop_at = taken_count + quota;
        while (taken_count < stop_at)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                send_frame(make_frame(1'($urandom_range(0, 1))), 40);
            else if (r < 82)
                send_frame(make_frame(1'b1), int'($urandom_range(1, 39)));
            else if (r < 97)
            begin
                repeat ($urandom_range(1, 4))
                    send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            end
            else
                wait_results();
        end
    endtask

    initial
    begin
        logic [TICK_W-1:0] thr_list[7];
        thr_list = '{8'd0, 8'd255, 8'd1, 8'd254, 8'd0, 8'd0, THRESHOLD_RESET};
        thr_list[4] = 8'($urandom_range(2, 253));
        thr_list[5] = 8'($urandom_range(2, 253));

        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_wdata         <= '0;
        in_ch.valid       <= 1'b0;
        in_ch.action      <= ACT_START;
        in_ch.pulse_ticks <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: pulses before any start are dropped.
        send_item(ACT_PULSE, 8'd255);
        send_item(ACT_PULSE, 8'd0);
        // Start during a frame discards the partial bits.
        send_item(ACT_START, 8'd0);
        send_item(ACT_PULSE, 8'd255);
        send_item(ACT_PULSE, THRESHOLD_RESET);
        send_item(ACT_PULSE, THRESHOLD_RESET + 8'd1);
        // Full frame with extreme bytes and a checksum that wraps past 8 bits.
        send_frame({8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFE}, 40);
        // Pulse right after a completed frame is ignored again.
        send_item(ACT_PULSE, 8'd255);
        send_frame({8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00}, 40);
        random_phase(ITEMS_PER_PHASE);

        foreach (thr_list[i])
        begin
            write_threshold(thr_list[i]);
            steady = (i % 3 == 2);
            if (i == 0)
                send_frame({8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFE}, 40);
            random_phase(ITEMS_PER_PHASE);
        end
        steady = 1'b0;

        wait_results();
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> single_wire_sensor_frame_receiver.f
design/swsfr_pkg.sv
design/swsfr_if.sv
design/swsfr_assembler.sv
design/swsfr_out_buf.sv
design/single_wire_sensor_frame_receiver.sv
tb/tb_single_wire_sensor_frame_receiver.sv
